@@ hw/rtl/skc_pkg.sv @@
// shared constants and controller/datapath handshake types for the smallest-k selector
package skc_pkg;

  localparam int K_MAX    = 16;
  localparam int CNT_W    = $clog2(K_MAX + 1);
  localparam int IDX_W    = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int VAL_W    = 32;
  localparam int KEEP_W   = 5;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

  typedef struct packed {
    logic step;   // accept one input beat
    logic load;   // move the next kept entry into the output register
  } skc_cmd_t;

  typedef struct packed {
    logic emit_go;    // the beat on the input starts an emission run
    logic idx_zero;   // next entry to emit is the smallest one
    logic out_valid;  // output register holds a beat
  } skc_sts_t;

endpackage

@@ hw/rtl/skc_ctrl.sv @@
// controller: collect / emit sequencing for the smallest-k selector
module skc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                out_tready,
  input  skc_pkg::skc_sts_t   sts,
  output skc_pkg::skc_cmd_t   cmd
);

  localparam logic ST_COLLECT = 1'b0;
  localparam logic ST_EMIT    = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;
  logic out_free;

  assign in_tready = (state_r == ST_COLLECT);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !sts.out_valid || out_tready;

  always_comb begin
    cmd.step  = accept;
    cmd.load  = (state_r == ST_EMIT) && out_free;
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (accept && sts.emit_go) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.load && sts.idx_zero) state_nxt = ST_COLLECT;
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/skc_dpath.sv @@
// datapath: sorted keep array with parallel compare-and-shift insert, counters, output register
module skc_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [skc_pkg::KEEP_W-1:0]        cfg_wr_data,
  input  logic [skc_pkg::VAL_W-1:0]         in_value,
  input  logic                              in_last,
  input  skc_pkg::skc_cmd_t                 cmd,
  output skc_pkg::skc_sts_t                 sts,
  input  logic                              out_tready,
  output logic [skc_pkg::VAL_W-1:0]         out_value,
  output logic                              out_last,
  output logic                              out_valid
);

  localparam int KM = skc_pkg::K_MAX;
  localparam int CW = skc_pkg::CNT_W;
  localparam int IW = skc_pkg::IDX_W;
  localparam int VW = skc_pkg::VAL_W;

  logic [skc_pkg::KEEP_W-1:0] keep_count_r;
  logic [VW-1:0]              kept_r [KM];
  logic [CW-1:0]              held_r;
  logic [CW-1:0]              seen_r;
  logic [IW-1:0]              idx_r;
  logic [VW-1:0]              out_value_r;
  logic                       out_last_r;
  logic                       out_valid_r;

  logic [CW-1:0] k_eff;
  logic [CW-1:0] h_eff;
  logic [CW-1:0] km1;
  logic [CW-1:0] n_ins;
  logic [CW-1:0] n_m1;
  logic [CW-1:0] held_new;
  logic [CW-1:0] seen_new;
  logic          do_ins;
  logic [KM-1:0] gt;
  logic [KM-1:0] wr;
  logic [VW-1:0] new_val [KM];
  int            k_int;

  always_comb begin
    k_int = (int'(keep_count_r) > KM) ? KM : int'(keep_count_r);
    k_eff = CW'(k_int);
    h_eff = (held_r > k_eff) ? k_eff : held_r;
    km1   = k_eff - CW'(1);
    for (int j = 0; j < KM; j++) begin
      gt[j] = $signed(kept_r[j]) > $signed(in_value);
    end
    do_ins = 1'b0;
    n_ins  = h_eff;
    if (k_eff != '0) begin
      if (h_eff < k_eff) begin
        do_ins = 1'b1;
        n_ins  = h_eff + CW'(1);
      end else if (gt[km1[IW-1:0]]) begin
        do_ins = 1'b1;
        n_ins  = k_eff;
      end
    end
    n_m1     = n_ins - CW'(1);
    held_new = do_ins ? n_ins : h_eff;
    seen_new = (seen_r < CW'(KM)) ? seen_r + CW'(1) : seen_r;
    // ties land after equal entries, so a match never pushes an older value out
    for (int p = 0; p < KM; p++) begin
      wr[p] = do_ins && (CW'(p) < n_ins);
      if (p > 0 && gt[(p > 0) ? p - 1 : 0]) begin
        new_val[p] = kept_r[(p > 0) ? p - 1 : 0];
      end else if (CW'(p) == n_m1 || gt[p]) begin
        new_val[p] = in_value;
      end else begin
        new_val[p] = kept_r[p];
      end
    end
    sts.emit_go   = in_last && (k_eff != '0) && (seen_new >= k_eff) && (held_new != '0);
    sts.idx_zero  = (idx_r == '0);
    sts.out_valid = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      for (int p = 0; p < KM; p++) begin
        if (wr[p]) kept_r[p] <= new_val[p];
      end
      if (sts.emit_go) idx_r <= IW'(held_new - CW'(1));
    end else if (cmd.load) begin
      idx_r <= idx_r - IW'(1);
    end
    if (cmd.load) begin
      out_value_r <= kept_r[idx_r];
      out_last_r  <= (idx_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= skc_pkg::KEEP_RESET;
      held_r       <= '0;
      seen_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) keep_count_r <= cfg_wr_data;
      if (cmd.step) begin
        held_r <= in_last ? '0 : held_new;
        seen_r <= in_last ? '0 : seen_new;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_value = out_value_r;
  assign out_last  = out_last_r;
  assign out_valid = out_valid_r;

endmodule

@@ hw/rtl/smallest_k_selector.sv @@
// top level of the smallest-k selector: controller plus datapath
// Usage:
//   in_*  : one signed 32-bit value per beat, tlast marks the final value of a set.
//   out_* : on the final value, if at least k values were seen, the kept values (up to
//           k, the smallest seen) leave largest first, one per beat, tlast on the smallest.
//   cfg_* : write keep_count (k, 1..16; larger values act as 16, zero emits nothing).
//           Write only while the block is idle.
// Input beats are accepted back to back while collecting; every value is placed by a
// parallel compare-and-shift over the 16-entry sorted register array.
// A set's final beat is followed by up to k output beats, one per cycle while the
// receiver is ready, read out of that array by a down counter; in_tready stays low
// until the last of them has been loaded into the output register.
// The first result beat is loaded once the controller has entered its emit state.
// Reset (rst_n low, synchronous): keep_count returns to 16, counts clear, output
// register empties. A stalled receiver holds the output register and the readout;
// input is taken again as soon as the final beat of a run sits in the output register.
module smallest_k_selector (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [skc_pkg::KEEP_W-1:0]         cfg_wr_data,   // keep_count
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [skc_pkg::VAL_W-1:0]          in_tdata,      // sample_value
  input  logic                               in_tlast,      // is_last
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [skc_pkg::VAL_W-1:0]          out_tdata,     // kept_value
  output logic                               out_tlast      // run_end
);

  skc_pkg::skc_cmd_t cmd;
  skc_pkg::skc_sts_t sts;

  skc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  skc_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_value    (in_tdata),
    .in_last     (in_tlast),
    .cmd         (cmd),
    .sts         (sts),
    .out_tready  (out_tready),
    .out_value   (out_tdata),
    .out_last    (out_tlast),
    .out_valid   (out_tvalid)
  );

endmodule

@@ hw/rtl/skc_checker.sv @@
// port-level checker for the smallest-k selector, bound to the top level
module skc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               in_tlast,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [skc_pkg::VAL_W-1:0]          out_tdata,
  input logic                               out_tlast
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // input is closed while a run is still being read out
  a_no_input_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input open in the middle of a run");

  // a beat that does not end the set never starts output
  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast && !out_tvalid |=> !out_tvalid)
    else $error("output without a final input beat");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind smallest_k_selector skc_checker u_skc_checker (.*);

@@ sim/tb_top.sv @@
// self-checking testbench for the smallest-k selector: directed table, then random sets
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VAL_W  = skc_pkg::VAL_W;
  localparam int KEEP_W = skc_pkg::KEEP_W;
  localparam int K_MAX  = skc_pkg::K_MAX;
  localparam logic [KEEP_W-1:0] KEEP_RESET = skc_pkg::KEEP_RESET;

  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 6;
  localparam int TOTAL_ITEMS   = 350;
  localparam int DIR_ROWS      = 29;

  typedef enum logic {ROW_KEEP, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [VAL_W-1:0] data;         // sample value, or keep_count for ROW_KEEP
    logic             last;
    logic             typed;        // single result beat typed in below
    logic [VAL_W-1:0] typed_value;
  } stim_row_t;

  typedef struct packed {
    logic [VAL_W-1:0] kept_value;
    logic             run_end;
  } kept_beat_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [KEEP_W-1:0] cfg_wr_data;
  logic              in_tvalid;
  logic              in_tready;
  logic [VAL_W-1:0]  in_tdata;    // sample_value
  logic              in_tlast;    // is_last
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [VAL_W-1:0]  out_tdata;   // kept_value
  logic              out_tlast;   // run_end

  smallest_k_selector dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state: ascending sorted kept values
  logic signed [VAL_W-1:0] sorted_vals [K_MAX];
  int                      held_n;
  int                      seen_n;
  logic [KEEP_W-1:0]       keep_reg;
  kept_beat_t              pending_kept [$];

  int idle_pct = 10;
  int mismatches;
  int samples_sent;
  int sets_done;
  int beats_checked;
  int keep_writes;
  int quiet_cycles;
  kept_beat_t want;

  stim_row_t dir_rows [DIR_ROWS] = '{
    // fewer than k at reset keep count: nothing comes out
    '{ROW_SAMPLE, 32'd5,          1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, 32'hFFFF_FFF9,  1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, 32'd0,          1'b1, 1'b0, 32'd0},
    '{ROW_KEEP,   32'd1,          1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, 32'h7FFF_FFFF,  1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, 32'h8000_0000,  1'b1, 1'b1, 32'h8000_0000},
    '{ROW_SAMPLE, 32'h8000_0000,  1'b1, 1'b1, 32'h8000_0000},
    // equal value does not displace the kept one
    '{ROW_SAMPLE, 32'd3,          1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, 32'd3,          1'b1, 1'b1, 32'd3},
    // zero keep count
    '{ROW_KEEP,   32'd0,          1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, 32'd1,          1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, 32'd2,          1'b1, 1'b0, 32'd0},
    // keep count above the maximum saturates
    '{ROW_KEEP,   32'd31,         1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, 32'hFFFF_FFFF,  1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, 32'd0,          1'b1, 1'b0, 32'd0},
    // keep count lowered in the middle of a set
    '{ROW_KEEP,   32'd4,          1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, 32'd10,         1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, 32'hFFFF_FFFF,  1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, 32'd7,          1'b0, 1'b0, 32'd0},
    '{ROW_KEEP,   32'd2,          1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, 32'd5,          1'b1, 1'b0, 32'd0},
    // lowered then raised: fewer held than k but enough seen
    '{ROW_KEEP,   32'd3,          1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, 32'd4,          1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, 32'd6,          1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, 32'd2,          1'b0, 1'b0, 32'd0},
    '{ROW_KEEP,   32'd1,          1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, 32'd9,          1'b0, 1'b0, 32'd0},
    '{ROW_KEEP,   32'd3,          1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, 32'd1,          1'b1, 1'b0, 32'd0}
  };

  function automatic int effective_keep();
    return (keep_reg > K_MAX) ? K_MAX : int'(keep_reg);
  endfunction

  // updates the sorted set for one accepted sample, queues the readout on the last one
  function automatic void track_smallest(input logic signed [VAL_W-1:0] v, input logic last,
                                         input bit record);
    int k;
    int n;
    int pos;
    int i;
    k = effective_keep();
    if (held_n > k) held_n = k;
    if (k > 0) begin
      n = 0;
      if (held_n < k) n = held_n + 1;
      else if (v < sorted_vals[k-1]) n = k;
      if (n > 0) begin
        pos = n - 1;
        while (pos > 0 && sorted_vals[pos-1] > v) begin
          sorted_vals[pos] = sorted_vals[pos-1];
          pos--;
        end
        sorted_vals[pos] = v;
        held_n = n;
      end
    end
    if (seen_n < K_MAX) seen_n++;
    if (last) begin
      if (record && k > 0 && seen_n >= k && held_n > 0) begin
        for (i = held_n; i > 0; i--)
          pending_kept.push_back('{kept_value: sorted_vals[i-1], run_end: (i == 1)});
      end
      seen_n = 0;
      held_n = 0;
      sets_done++;
    end
  endfunction

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  task automatic push_sample(input logic [VAL_W-1:0] v, input logic last, input logic typed,
                             input logic [VAL_W-1:0] typed_value);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = v;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
    track_smallest(v, last, !typed);
    if (typed) pending_kept.push_back('{kept_value: typed_value, run_end: 1'b1});
  endtask

  // sender holds off until every queued result has left, then lets the pipe settle
  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_kept.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] k);
    drain_results();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = k;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    keep_reg  = k;
    keep_writes++;
  endtask

  function automatic logic [VAL_W-1:0] pick_value(input int mode);
    logic [VAL_W-1:0] v;
    v = $urandom;
    case (mode)
      1: begin
        v = $urandom_range(6) - 3;  // narrow range forces duplicates
      end
      2: begin
        case ($urandom_range(4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'd0;
          3: v = 32'hFFFF_FFFF;
          default: v = $urandom;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      beats_checked++;
      if (pending_kept.size() == 0) begin
        flag_error($sformatf("unexpected beat data=%h last=%b", out_tdata, out_tlast));
      end else begin
        want = pending_kept.pop_front();
        if (out_tdata !== want.kept_value || out_tlast !== want.run_end)
          flag_error($sformatf("data=%h last=%b, expected data=%h last=%b",
                               out_tdata, out_tlast, want.kept_value, want.run_end));
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d results outstanding",
               quiet_cycles, pending_kept.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int r;
    int phase;
    int sets;
    int len;
    int k_eff;
    int mode;
    int j;
    logic [KEEP_W-1:0] keep_pick;

    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    keep_reg    = KEEP_RESET;
    held_n      = 0;
    seen_n      = 0;
    mismatches  = 0;
    samples_sent  = 0;
    sets_done     = 0;
    beats_checked = 0;
    keep_writes   = 0;
    quiet_cycles  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_KEEP)
        write_keep(dir_rows[r].data[KEEP_W-1:0]);
      else
        push_sample(dir_rows[r].data, dir_rows[r].last, dir_rows[r].typed,
                    dir_rows[r].typed_value);
    end

    phase = 0;
    while (samples_sent < TOTAL_ITEMS) begin
      phase++;
      // one long stretch with no stalls on either side
      if (phase == 4) idle_pct = 0;
      else if (phase == 9) idle_pct = 10;
      r = $urandom_range(99);
      if (r < 8) keep_pick = 5'd0;
      else if (r < 16) keep_pick = KEEP_W'($urandom_range(31, 17));
      else if (r < 32) keep_pick = 5'd16;
      else if (r < 42) keep_pick = 5'd1;
      else keep_pick = KEEP_W'($urandom_range(15, 1));
      write_keep(keep_pick);
      k_eff = effective_keep();
      sets = $urandom_range(4, 1);
      repeat (sets) begin
        if ($urandom_range(99) < 15) len = $urandom_range((k_eff > 1) ? k_eff : 1, 1);
        else len = k_eff + $urandom_range(8);
        if (len == 0) len = 1;
        mode = $urandom_range(2);
        for (j = 0; j < len; j++)
          push_sample(pick_value(mode), (j == len - 1), 1'b0, '0);
      end
    end

    drain_results();
    $display("%0d samples in %0d sets, %0d result beats checked", samples_sent, sets_done,
             beats_checked);
    $display("%0d keep_count writes incl. zero, one, full and saturating", keep_writes);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
